// ===== sv/wpc_pkg.sv =====
// ----------------------------------------------------------------------------
// wpc_pkg
// Shared constants, register codes and types for the windowed pid controller.
// ----------------------------------------------------------------------------
package wpc_pkg;

	localparam int WINDOW  = 10;
	localparam int SLOT_W  = $clog2(WINDOW);
	localparam int ERR_W   = 16;
	localparam int GAIN_W  = 16;
	localparam int MAXI_W  = 20;
	localparam int SUM_W   = ERR_W + $clog2(WINDOW);
	localparam int ISUM_W  = (SUM_W > MAXI_W) ? SUM_W : MAXI_W;
	localparam int P_W     = GAIN_W + ERR_W;
	localparam int D_W     = GAIN_W + ERR_W + 1;
	localparam int PD_W    = D_W + 1;
	localparam int I_W     = GAIN_W + ISUM_W;
	localparam int ACC_W   = I_W + 2;
	localparam int DRIVE_W = 32;
	localparam int ADDR_W  = 5;
	localparam int DATA_W  = 32;

	typedef enum logic [2:0] {
		REG_KP   = 3'd0,
		REG_KD   = 3'd1,
		REG_KI   = 3'd2,
		REG_MAXI = 3'd3,
		REG_TOL  = 3'd4
	} reg_idx_t;

	localparam logic signed [GAIN_W-1:0] KP_RST   = 16'sd512;
	localparam logic signed [GAIN_W-1:0] KD_RST   = 16'sd0;
	localparam logic signed [GAIN_W-1:0] KI_RST   = 16'sd0;
	localparam logic signed [MAXI_W-1:0] MAXI_RST = 20'sd40960;
	localparam logic signed [ERR_W-1:0]  TOL_RST  = 16'sd41;

	typedef struct packed {
		logic signed [GAIN_W-1:0] kp;
		logic signed [GAIN_W-1:0] kd;
		logic signed [GAIN_W-1:0] ki;
		logic signed [MAXI_W-1:0] max_integral;
		logic signed [ERR_W-1:0]  tolerance;
	} cfg_t;

	// word passed from the window stage to the multiply stages
	typedef struct packed {
		logic signed [ERR_W-1:0] e;
		logic signed [ERR_W:0]   diff;
		logic signed [SUM_W-1:0] sum;
	} win_t;

endpackage

// ===== sv/wpc_regs.sv =====
// ----------------------------------------------------------------------------
// wpc_regs
// Configuration register file behind an apb-style port.
// ----------------------------------------------------------------------------
module wpc_regs (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [wpc_pkg::ADDR_W-1:0]   paddr,
	input  logic [wpc_pkg::DATA_W-1:0]   pwdata,
	output logic [wpc_pkg::DATA_W-1:0]   prdata,
	output logic                         pready,
	output wpc_pkg::cfg_t                cfg
);

	logic signed [wpc_pkg::GAIN_W-1:0] kp_q;
	logic signed [wpc_pkg::GAIN_W-1:0] kd_q;
	logic signed [wpc_pkg::GAIN_W-1:0] ki_q;
	logic signed [wpc_pkg::MAXI_W-1:0] maxi_q;
	logic signed [wpc_pkg::ERR_W-1:0]  tol_q;
	logic [2:0]                        idx;
	logic                              wr_en;

	assign idx    = paddr[wpc_pkg::ADDR_W-1:2];
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kp_q   <= wpc_pkg::KP_RST;
			kd_q   <= wpc_pkg::KD_RST;
			ki_q   <= wpc_pkg::KI_RST;
			maxi_q <= wpc_pkg::MAXI_RST;
			tol_q  <= wpc_pkg::TOL_RST;
		end else if (wr_en) begin
			unique case (idx)
				wpc_pkg::REG_KP:   kp_q   <= pwdata[wpc_pkg::GAIN_W-1:0];
				wpc_pkg::REG_KD:   kd_q   <= pwdata[wpc_pkg::GAIN_W-1:0];
				wpc_pkg::REG_KI:   ki_q   <= pwdata[wpc_pkg::GAIN_W-1:0];
				wpc_pkg::REG_MAXI: maxi_q <= pwdata[wpc_pkg::MAXI_W-1:0];
				wpc_pkg::REG_TOL:  tol_q  <= pwdata[wpc_pkg::ERR_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			wpc_pkg::REG_KP:   prdata = wpc_pkg::DATA_W'(kp_q);
			wpc_pkg::REG_KD:   prdata = wpc_pkg::DATA_W'(kd_q);
			wpc_pkg::REG_KI:   prdata = wpc_pkg::DATA_W'(ki_q);
			wpc_pkg::REG_MAXI: prdata = wpc_pkg::DATA_W'(maxi_q);
			wpc_pkg::REG_TOL:  prdata = wpc_pkg::DATA_W'(tol_q);
			default:           prdata = '0;
		endcase
	end

	assign cfg.kp           = kp_q;
	assign cfg.kd           = kd_q;
	assign cfg.ki           = ki_q;
	assign cfg.max_integral = maxi_q;
	assign cfg.tolerance    = tol_q;

endmodule

// ===== sv/wpc_window.sv =====
// ----------------------------------------------------------------------------
// wpc_window
// Error ring in a synchronous memory with a running window sum: reads the
// oldest entry, then writes the new sample over it and updates the sum.
// ----------------------------------------------------------------------------
module wpc_window (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic signed [wpc_pkg::ERR_W-1:0] in_err,
	output logic                             out_valid,
	input  logic                             out_ready,
	output wpc_pkg::win_t                    out_word
);

	logic signed [wpc_pkg::ERR_W-1:0] ring_mem [wpc_pkg::WINDOW];
	logic [wpc_pkg::WINDOW-1:0]       filled_q;
	logic [wpc_pkg::SLOT_W-1:0]       write_slot_q;
	logic [wpc_pkg::SLOT_W-1:0]       nxt_slot;
	logic signed [wpc_pkg::SUM_W-1:0] sum_q;
	logic signed [wpc_pkg::ERR_W-1:0] prev_q;

	logic                             vld_s1;
	logic signed [wpc_pkg::ERR_W-1:0] e_s1;
	logic [wpc_pkg::SLOT_W-1:0]       slot_s1;
	logic signed [wpc_pkg::ERR_W-1:0] rd_s1;
	logic                             filled_s1;

	logic                             vld_s2;
	wpc_pkg::win_t                    word_s2;

	logic                             rdy_s1;
	logic                             rdy_s2;
	logic                             acc;
	logic                             adv;
	logic signed [wpc_pkg::ERR_W-1:0] old;
	logic signed [wpc_pkg::SUM_W-1:0] sum_new;

	assign rdy_s2   = !vld_s2 || out_ready;
	assign rdy_s1   = !vld_s1 || rdy_s2;
	assign in_ready = rdy_s1;
	assign acc      = in_valid && rdy_s1;
	assign adv      = vld_s1 && rdy_s2;

	assign nxt_slot = (write_slot_q == wpc_pkg::SLOT_W'(wpc_pkg::WINDOW - 1)) ?
		'0 : write_slot_q + 1'b1;

	// entries never written since reset count as zero
	assign old     = filled_s1 ? rd_s1 : '0;
	assign sum_new = sum_q - wpc_pkg::SUM_W'(old) + wpc_pkg::SUM_W'(e_s1);

	// the slot read by a new word always differs from the one written back
	always_ff @(posedge clk) begin
		if (adv)
			ring_mem[slot_s1] <= e_s1;
		if (acc) begin
			rd_s1     <= ring_mem[nxt_slot];
			filled_s1 <= filled_q[nxt_slot];
			e_s1      <= in_err;
			slot_s1   <= nxt_slot;
		end
		if (adv) begin
			word_s2.e    <= e_s1;
			word_s2.diff <= (wpc_pkg::ERR_W + 1)'(e_s1) - (wpc_pkg::ERR_W + 1)'(prev_q);
			word_s2.sum  <= sum_new;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			filled_q     <= '0;
			write_slot_q <= '0;
			sum_q        <= '0;
			prev_q       <= '0;
			vld_s1       <= 1'b0;
			vld_s2       <= 1'b0;
		end else begin
			if (acc)
				write_slot_q <= nxt_slot;
			if (adv) begin
				filled_q[slot_s1] <= 1'b1;
				sum_q             <= sum_new;
				prev_q            <= e_s1;
			end
			if (rdy_s1)
				vld_s1 <= in_valid;
			if (rdy_s2)
				vld_s2 <= vld_s1;
		end
	end

	assign out_valid = vld_s2;
	assign out_word  = word_s2;

endmodule

// ===== sv/wpc_mac.sv =====
// ----------------------------------------------------------------------------
// wpc_mac
// Clamp, three gain multiplies, final add with 32-bit saturation and the
// output register.
// ----------------------------------------------------------------------------
module wpc_mac (
	input  logic                               clk,
	input  logic                               arst_n,
	input  wpc_pkg::cfg_t                      cfg,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  wpc_pkg::win_t                      in_word,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic signed [wpc_pkg::DRIVE_W-1:0] drive,
	output logic                               at_target
);

	logic                              vld_s3;
	logic signed [wpc_pkg::P_W-1:0]    p_s3;
	logic signed [wpc_pkg::D_W-1:0]    d_s3;
	logic signed [wpc_pkg::ISUM_W-1:0] isum_s3;
	logic                              at_s3;

	logic                              vld_s4;
	logic signed [wpc_pkg::PD_W-1:0]   pd_s4;
	logic signed [wpc_pkg::I_W-1:0]    i_s4;
	logic                              at_s4;

	logic                               vld_q;
	logic signed [wpc_pkg::DRIVE_W-1:0] drive_q;
	logic                               at_q;

	logic                              rdy_s3;
	logic                              rdy_s4;
	logic                              rdy_o;
	logic signed [wpc_pkg::ISUM_W-1:0] sum_x;
	logic signed [wpc_pkg::ISUM_W-1:0] maxi_x;
	logic signed [wpc_pkg::ACC_W-1:0]  acc;
	logic [wpc_pkg::ACC_W-wpc_pkg::DRIVE_W:0] top_bits;
	logic signed [wpc_pkg::DRIVE_W-1:0] sat;

	assign rdy_o    = !vld_q || out_ready;
	assign rdy_s4   = !vld_s4 || rdy_o;
	assign rdy_s3   = !vld_s3 || rdy_s4;
	assign in_ready = rdy_s3;

	// window sum is clamped from above only
	assign sum_x  = wpc_pkg::ISUM_W'(in_word.sum);
	assign maxi_x = wpc_pkg::ISUM_W'(cfg.max_integral);

	assign acc      = wpc_pkg::ACC_W'(pd_s4) + wpc_pkg::ACC_W'(i_s4);
	assign top_bits = acc[wpc_pkg::ACC_W-1:wpc_pkg::DRIVE_W-1];

	always_comb begin
		if ((&top_bits) || !(|top_bits))
			sat = acc[wpc_pkg::DRIVE_W-1:0];
		else if (acc[wpc_pkg::ACC_W-1])
			sat = {1'b1, {(wpc_pkg::DRIVE_W-1){1'b0}}};
		else
			sat = {1'b0, {(wpc_pkg::DRIVE_W-1){1'b1}}};
	end

	always_ff @(posedge clk) begin
		if (in_valid && rdy_s3) begin
			p_s3    <= cfg.kp * in_word.e;
			d_s3    <= cfg.kd * in_word.diff;
			isum_s3 <= (sum_x > maxi_x) ? maxi_x : sum_x;
			at_s3   <= (in_word.e <= cfg.tolerance);
		end
		if (vld_s3 && rdy_s4) begin
			pd_s4 <= wpc_pkg::PD_W'(p_s3) + wpc_pkg::PD_W'(d_s3);
			i_s4  <= cfg.ki * isum_s3;
			at_s4 <= at_s3;
		end
		if (vld_s4 && rdy_o) begin
			drive_q <= sat;
			at_q    <= at_s4;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_q  <= 1'b0;
		end else begin
			if (rdy_s3)
				vld_s3 <= in_valid;
			if (rdy_s4)
				vld_s4 <= vld_s3;
			if (rdy_o)
				vld_q <= vld_s4;
		end
	end

	assign out_valid = vld_q;
	assign drive     = drive_q;
	assign at_target = at_q;

endmodule

// ===== sv/windowed_pid_controller.sv =====
// ----------------------------------------------------------------------------
// windowed_pid_controller
// PID controller with an integral over the last WINDOW error words.
//
//   channel   dir   payload
//   s_*       in    tdata[15:0] error_sample, signed Q4.12
//   m_*       out   tdata[31:0] drive, signed Q12.20; tuser[0] at_target
//   apb       in    kp, kd, ki, max_integral, tolerance at 4*index
//
// One word per cycle sustained while the output is not stalled. The ring
// read and write-back use the two ports of the ring memory in the same
// cycle at different slots, so no interlock is needed. Reset clears the
// slot pointer, window sum and per-entry fill bits at once, with no
// clearing pass. Each stage holds its word while stalled and bubbles ahead
// of a stalled output are filled, so tready drops only when full.
// ----------------------------------------------------------------------------
module windowed_pid_controller (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [15:0]                       s_tdata,   // [15:0] error_sample
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [31:0]                       m_tdata,   // [31:0] drive
	output logic                              m_tuser,   // [0] at_target
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [wpc_pkg::ADDR_W-1:0]        paddr,
	input  logic [wpc_pkg::DATA_W-1:0]        pwdata,
	output logic [wpc_pkg::DATA_W-1:0]        prdata,
	output logic                              pready
);

	wpc_pkg::cfg_t                      cfg;
	logic                               win_valid;
	logic                               win_ready;
	wpc_pkg::win_t                      win_word;
	logic signed [wpc_pkg::DRIVE_W-1:0] drive;

	wpc_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	wpc_window u_window (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_err    (s_tdata),
		.out_valid (win_valid),
		.out_ready (win_ready),
		.out_word  (win_word)
	);

	wpc_mac u_mac (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.in_valid  (win_valid),
		.in_ready  (win_ready),
		.in_word   (win_word),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.drive     (drive),
		.at_target (m_tuser)
	);

	assign m_tdata = drive;

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the windowed pid controller. Error words go in on
// the slave stream, and each command word that leaves the master stream is
// compared with a local prediction of the ring, window sum, clamp and
// saturation. Gains and limits are set over apb between phases.
// ----------------------------------------------------------------------------
module tb_top;

	localparam int PIPE_LAT   = 5;
	localparam int REG_UNUSED = 7;
	localparam int PHASES     = 9;
	localparam int PHASE_LEN  = 150;

	typedef struct {
		logic signed [31:0] drive;
		logic               at_target;
	} command_t;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              s_tvalid;
	logic              s_tready;
	logic [15:0]       s_tdata;   // [15:0] error_sample
	logic              m_tvalid;
	logic              m_tready = 1'b0;
	logic [31:0]       m_tdata;   // [31:0] drive
	logic              m_tuser;   // [0] at_target
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [wpc_pkg::ADDR_W-1:0] paddr;
	logic [wpc_pkg::DATA_W-1:0] pwdata;
	logic [wpc_pkg::DATA_W-1:0] prdata;
	logic              pready;

	// local copy of the controller state and registers
	longint            cfg_kp   = 512;
	longint            cfg_kd   = 0;
	longint            cfg_ki   = 0;
	longint            cfg_maxi = 40960;
	longint            cfg_tol  = 41;
	logic signed [15:0] err_ring [wpc_pkg::WINDOW] = '{default: '0};
	int unsigned       ring_slot = 0;
	longint            win_total = 0;

	command_t          expected_cmds [$];
	int                fail_count = 0;
	int                gap_max    = 0;
	int                burst_left = 0;
	int                rx_mode    = 0;
	int unsigned       rx_count   = 0;

	windowed_pid_controller dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	always #5 clk = ~clk;

	initial begin
		#5_000_000;
		$display("Verification failed");
		$finish;
	end

	// receiver stall pattern
	always @(negedge clk) begin
		rx_count <= rx_count + 1;
		case (rx_mode)
			0: m_tready <= 1'b1;
			1: m_tready <= ($urandom_range(0, 3) != 0);
			2: m_tready <= ((rx_count % 9) < 5);
			default: m_tready <= ($urandom_range(0, 1) != 0);
		endcase
	end

	task automatic predict_command(input logic signed [15:0] e);
		command_t    c;
		int unsigned nxt;
		longint      prev;
		longint      isum;
		longint      acc;
		nxt = (ring_slot + 1) % wpc_pkg::WINDOW;
		prev = err_ring[ring_slot];
		win_total = win_total - err_ring[nxt] + e;
		err_ring[nxt] = e;
		ring_slot = nxt;
		// clamp from above only
		isum = (win_total > cfg_maxi) ? cfg_maxi : win_total;
		acc = cfg_kp * e + cfg_kd * (longint'(e) - prev) + cfg_ki * isum;
		if (acc > 64'sd2147483647)
			acc = 64'sd2147483647;
		if (acc < -64'sd2147483648)
			acc = -64'sd2147483648;
		c.drive = acc[31:0];
		c.at_target = (longint'(e) <= cfg_tol);
		expected_cmds.push_back(c);
	endtask

	task automatic send_error(input logic signed [15:0] e);
		int gap;
		if (gap_max > 0 && burst_left == 0) begin
			gap = $urandom_range(1, gap_max);
			@(negedge clk);
			s_tvalid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
			burst_left = $urandom_range(1, 24);
		end
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata <= e;
		do @(posedge clk); while (!s_tready);
		predict_command(e);
		if (burst_left > 0)
			burst_left--;
	endtask

	task automatic wait_all_results();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (expected_cmds.size() != 0)
			@(posedge clk);
		repeat (PIPE_LAT) @(posedge clk);
		burst_left = 0;
	endtask

	task automatic apb_write(input int idx, input logic [31:0] val);
		@(negedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= wpc_pkg::ADDR_W'(idx * 4);
		pwdata <= val;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		case (idx)
			wpc_pkg::REG_KP:   cfg_kp = $signed(val[15:0]);
			wpc_pkg::REG_KD:   cfg_kd = $signed(val[15:0]);
			wpc_pkg::REG_KI:   cfg_ki = $signed(val[15:0]);
			wpc_pkg::REG_MAXI: cfg_maxi = $signed(val[19:0]);
			wpc_pkg::REG_TOL:  cfg_tol = $signed(val[15:0]);
			default: ;
		endcase
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic set_config(input longint kp, input longint kd, input longint ki,
			input longint maxi, input longint tol);
		wait_all_results();
		apb_write(wpc_pkg::REG_KP, kp[31:0]);
		apb_write(wpc_pkg::REG_KD, kd[31:0]);
		apb_write(wpc_pkg::REG_KI, ki[31:0]);
		apb_write(wpc_pkg::REG_MAXI, maxi[31:0]);
		apb_write(wpc_pkg::REG_TOL, tol[31:0]);
	endtask

	function automatic longint pick_reg(input int width);
		longint lo;
		longint hi;
		lo = -(64'sd1 <<< (width - 1));
		hi = (64'sd1 <<< (width - 1)) - 1;
		case ($urandom_range(0, 5))
			0: return lo;
			1: return hi;
			2: return longint'($urandom_range(0, 1200)) - 600;
			default: return longint'($urandom_range(0, 32'(hi - lo))) + lo;
		endcase
	endfunction

	function automatic logic signed [15:0] extreme_error();
		case ($urandom_range(0, 3))
			0: return 16'sh7fff;
			1: return 16'sh8000;
			2: return 16'sh0000;
			default: return 16'shffff;
		endcase
	endfunction

	always @(posedge clk) begin
		command_t want;
		if (m_tvalid && m_tready) begin
			if (expected_cmds.size() == 0) begin
				$display("%0t: unexpected word drive=%0d at_target=%0b",
					$time, $signed(m_tdata), m_tuser);
				fail_count++;
			end else begin
				want = expected_cmds.pop_front();
				if (m_tdata !== want.drive) begin
					$display("%0t: drive mismatch expected %0d actual %0d",
						$time, want.drive, $signed(m_tdata));
					fail_count++;
				end
				if (m_tuser !== want.at_target) begin
					$display("%0t: at_target mismatch expected %0b actual %0b",
						$time, want.at_target, m_tuser);
					fail_count++;
				end
			end
		end
	end

	// reset gains, first ticks with zero history, tolerance boundary
	task automatic test_reset_config();
		gap_max = 0;
		rx_mode = 0;
		send_error(16'sd0);
		send_error(16'sd32767);
		send_error(-16'sd32768);
		send_error(16'sd41);
		send_error(16'sd42);
		send_error(-16'sd1);
	endtask

	// full-scale gains and errors drive the sum into both saturation rails
	task automatic test_gain_extremes();
		set_config(32767, 32767, 32767, 524287, -32768);
		rx_mode = 2;
		send_error(16'sd32767);
		send_error(-16'sd32768);
		send_error(16'sd32767);
		send_error(-16'sd32768);
		set_config(-32768, -32768, -32768, -524288, 32767);
		rx_mode = 1;
		gap_max = 3;
		send_error(-16'sd32768);
		send_error(16'sd32767);
		send_error(-16'sd32768);
		send_error(16'sd32767);
	endtask

	// window sum above the clamp, far below it, and a negative clamp
	task automatic test_integral_clamp();
		set_config(0, 0, 256, 4096, 0);
		rx_mode = 0;
		gap_max = 0;
		send_error(16'sd30000);
		send_error(16'sd30000);
		send_error(-16'sd32768);
		send_error(-16'sd32768);
		send_error(-16'sd32768);
		set_config(0, 0, -256, -20000, 0);
		send_error(-16'sd32768);
		send_error(16'sd32767);
		send_error(16'sd32767);
	endtask

	// a write past the last register must change nothing
	task automatic test_unused_register();
		wait_all_results();
		apb_write(REG_UNUSED, $urandom);
		send_error(16'sd1000);
		send_error(-16'sd1000);
	endtask

	task automatic test_random_stream();
		int   sel;
		int   v;
		logic streak_pos;
		logic signed [15:0] e;
		streak_pos = 1'b1;
		for (int ph = 0; ph < PHASES; ph++) begin
			if (ph == 0)
				set_config(32767, 32767, 32767, 524287, 32767);
			else if (ph == 1)
				set_config(-32768, -32768, -32768, -524288, -32768);
			else
				set_config(pick_reg(16), pick_reg(16), pick_reg(16), pick_reg(20),
					pick_reg(16));
			rx_mode = ph % 4;
			gap_max = (ph % 3 == 0) ? 0 : $urandom_range(1, 8);
			for (int n = 0; n < PHASE_LEN; n++) begin
				sel = $urandom_range(0, 19);
				if (sel < 8) begin
					e = 16'($urandom);
				end else if (sel < 11) begin
					v = int'(cfg_tol) + $urandom_range(0, 4) - 2;
					if (v > 32767)
						v = 32767;
					if (v < -32768)
						v = -32768;
					e = v[15:0];
				end else if (sel < 13) begin
					e = extreme_error();
				end else begin
					// same-sign runs push the window sum toward the clamp
					if ($urandom_range(0, 11) == 0)
						streak_pos = ~streak_pos;
					v = $urandom_range(0, 32767);
					e = streak_pos ? v[15:0] : -v[15:0];
				end
				send_error(e);
				if (ph == 4 && n == PHASE_LEN / 2)
					wait_all_results();
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		test_reset_config();
		test_gain_extremes();
		test_integral_clamp();
		test_unused_register();
		test_random_stream();
		wait_all_results();
		repeat (PIPE_LAT * 4) @(posedge clk);
		if (fail_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
